[src/kmer_pkg.sv]
// Shared types, register indices and character constants for the k-mer symbol packer.
package kmer_pkg;

  localparam int CODE_BITS = 16;
  localparam int POS_BITS = 16;
  localparam int SHIFT_BITS = $clog2(CODE_BITS);
  localparam int SYM_BITS = 6;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_ALPHABET = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SYM_LIMIT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BPS = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORDER = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SKIP = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_WIDTH = 3'd5;

  localparam logic [1:0] MODE_DNA = 2'd0;
  localparam logic [1:0] MODE_PROTEIN = 2'd1;
  localparam logic [1:0] MODE_ALNUM = 2'd2;
  localparam logic [1:0] MODE_DIE = 2'd3;

  localparam logic [7:0] CH_NL = 8'h0a;
  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_C = 8'h43;
  localparam logic [7:0] CH_UP_G = 8'h47;
  localparam logic [7:0] CH_UP_T = 8'h54;
  localparam logic [7:0] CH_UP_N = 8'h4e;
  localparam logic [7:0] CH_LO_N = 8'h6e;
  localparam logic [7:0] CH_LO_A = 8'h61;
  localparam logic [7:0] CH_LO_B = 8'h62;
  localparam logic [7:0] CH_LO_J = 8'h6a;
  localparam logic [7:0] CH_LO_O = 8'h6f;
  localparam logic [7:0] CH_LO_U = 8'h75;
  localparam logic [7:0] CH_LO_Y = 8'h79;
  localparam logic [7:0] CH_LO_Z = 8'h7a;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_1 = 8'h31;
  localparam logic [7:0] CH_6 = 8'h36;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [SYM_BITS-1:0] DIGIT_BASE = 6'd26;

  typedef struct packed {
    logic [1:0]          alphabet_mode;
    logic [7:0]          symbol_limit;
    logic [3:0]          bits_per_symbol;
    logic [4:0]          window_order;
    logic [POS_BITS-1:0] start_skip;
    logic [POS_BITS-1:0] max_width;
  } cfg_t;

  typedef struct packed {
    logic       bad;
    logic [7:0] sym;
  } sym_t;

endpackage

[src/kmer_symbol_packer.sv]
// Top level: input register, line state, window update and result register.
// A byte that emits passes through the input register and then the result register to the output.
// Throughput: one byte per cycle; the line state updates as each byte leaves the
// input register, and a full stalled result register holds back only bytes that emit.
// Reset: synchronous, clears the line state and both valid flags, loads configuration defaults.
module kmer_symbol_packer
  import kmer_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               char_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [15:0]              packed_code,
  output logic                     is_line_end,
  output logic                     line_error,
  output logic [15:0]              line_count,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t cfg;
  sym_t sym_res;

  logic                 s1_valid;
  logic [7:0]           s1_char;
  logic                 s1_adv;
  logic                 is_nl;
  logic                 fire;
  logic                 produce;

  logic [CODE_BITS-1:0] window_reg;
  logic [CODE_BITS-1:0] window_next;
  logic [CODE_BITS-1:0] wmask;
  logic [8:0]           total;
  logic [POS_BITS-1:0]  position;
  logic [POS_BITS-1:0]  emitted;
  logic                 error_seen;

  kmer_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kmer_sym_map u_map (
    .char_in (s1_char),
    .cfg     (cfg),
    .res     (sym_res)
  );

  always_comb begin
    is_nl   = (s1_char == CH_NL);
    fire    = (position >= cfg.start_skip) &&
              ((cfg.max_width == '0) || (emitted < cfg.max_width));
    produce = is_nl || fire;
    s1_adv  = s1_valid && (!produce || !out_valid || out_ready);
    in_ready = !s1_valid || s1_adv;

    total = 9'(cfg.bits_per_symbol) * 9'(cfg.window_order);
    if (total >= 9'(CODE_BITS)) wmask = '1;
    else wmask = ~({CODE_BITS{1'b1}} << total[SHIFT_BITS-1:0]);
    window_next = ((window_reg << cfg.bits_per_symbol) |
                   CODE_BITS'(sym_res.sym)) & wmask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_char <= char_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_reg <= '0;
      position   <= '0;
      emitted    <= '0;
      error_seen <= 1'b0;
    end else if (s1_adv) begin
      if (is_nl) begin
        window_reg <= '0;
        position   <= '0;
        emitted    <= '0;
        error_seen <= 1'b0;
      end else begin
        window_reg <= window_next;
        if (position != '1) position <= position + POS_BITS'(1);
        if (fire && (emitted != '1)) emitted <= emitted + POS_BITS'(1);
        if (sym_res.bad) error_seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && produce) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_adv && produce) begin
      if (is_nl) begin
        packed_code <= '0;
        is_line_end <= 1'b1;
        line_error  <= error_seen;
        line_count  <= 16'(emitted);
      end else begin
        packed_code <= 16'(window_next);
        is_line_end <= 1'b0;
        line_error  <= 1'b0;
        line_count  <= '0;
      end
    end
  end

endmodule

[src/kmer_cfg_regs.sv]
// Configuration register file with range clamping on write.
module kmer_cfg_regs
  import kmer_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alphabet_mode   <= MODE_DNA;
      cfg.symbol_limit    <= 8'd4;
      cfg.bits_per_symbol <= 4'd2;
      cfg.window_order    <= 5'd1;
      cfg.start_skip      <= '0;
      cfg.max_width       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ALPHABET:  cfg.alphabet_mode <= cfg_data[1:0];
        REG_SYM_LIMIT: cfg.symbol_limit <= cfg_data[7:0];
        REG_BPS: begin
          if (cfg_data[3:0] == 4'd0) cfg.bits_per_symbol <= 4'd1;
          else if (cfg_data[3:0] > 4'd8) cfg.bits_per_symbol <= 4'd8;
          else cfg.bits_per_symbol <= cfg_data[3:0];
        end
        REG_ORDER: begin
          if (cfg_data[4:0] == 5'd0) cfg.window_order <= 5'd1;
          else if (cfg_data[4:0] > 5'd16) cfg.window_order <= 5'd16;
          else cfg.window_order <= cfg_data[4:0];
        end
        REG_SKIP:      cfg.start_skip <= cfg_data[POS_BITS-1:0];
        REG_MAX_WIDTH: cfg.max_width <= cfg_data[POS_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

[src/kmer_sym_map.sv]
// Character to symbol decoder with limit check and width cut.
module kmer_sym_map
  import kmer_pkg::*;
(
  input  logic [7:0] char_in,
  input  cfg_t       cfg,
  output sym_t       res
);

  logic                hit;
  logic [SYM_BITS-1:0] code;
  logic [SYM_BITS-1:0] gaps;
  logic [SYM_BITS-1:0] kept;
  logic [8:0]          bps_mask;

  always_comb begin
    hit  = 1'b0;
    code = '0;
    gaps = SYM_BITS'(char_in > CH_LO_B) + SYM_BITS'(char_in > CH_LO_J)
         + SYM_BITS'(char_in > CH_LO_O) + SYM_BITS'(char_in > CH_LO_U);
    case (cfg.alphabet_mode)
      MODE_PROTEIN: begin
        if ((char_in inside {[CH_LO_A:CH_LO_Y]}) &&
            !(char_in inside {CH_LO_B, CH_LO_J, CH_LO_O, CH_LO_U})) begin
          hit  = 1'b1;
          code = SYM_BITS'(char_in - CH_LO_A) - gaps;
        end
      end
      MODE_ALNUM: begin
        if (char_in inside {[CH_LO_A:CH_LO_Z]}) begin
          hit  = 1'b1;
          code = SYM_BITS'(char_in - CH_LO_A);
        end else if (char_in inside {[CH_0:CH_9]}) begin
          hit  = 1'b1;
          code = DIGIT_BASE + SYM_BITS'(char_in - CH_0);
        end
      end
      MODE_DIE: begin
        if (char_in inside {[CH_1:CH_6]}) begin
          hit  = 1'b1;
          code = SYM_BITS'(char_in - CH_1);
        end
      end
      default: begin
        hit = 1'b1;
        case (char_in)
          CH_UP_A: code = 6'd0;
          CH_UP_C: code = 6'd1;
          CH_UP_G: code = 6'd2;
          CH_UP_T: code = 6'd3;
          CH_UP_N: code = 6'd4;
          CH_LO_N: code = 6'd5;
          default: hit = 1'b0;
        endcase
      end
    endcase

    res.bad  = !hit || ({2'b00, code} >= cfg.symbol_limit);
    kept     = res.bad ? '0 : code;
    bps_mask = (9'd1 << cfg.bits_per_symbol) - 9'd1;
    res.sym  = {2'b00, kept} & bps_mask[7:0];
  end

endmodule

[bench/tb_top.sv]
// Self-checking bench for the k-mer symbol packer: directed lines and random lines.
module tb_top
  import kmer_pkg::*;
();

  localparam int GAP_PCT = 31;
  localparam int SETTLE_CYCLES = 4;
  localparam int SHOW_LIMIT = 10;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic [15:0] code;
    logic        line_end;
    logic        err;
    logic [15:0] count;
  } out_beat_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [7:0]               char_in;
  logic                     out_valid;
  logic                     out_ready;
  logic [15:0]              packed_code;
  logic                     is_line_end;
  logic                     line_error;
  logic [15:0]              line_count;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  cfg_t        shadow;
  logic [15:0] win_m;
  logic [15:0] pos_m;
  logic [15:0] emit_m;
  logic        err_m;
  out_beat_t   beats_due[$];
  int          bad_beats;
  bit          gaps_on;

  kmer_symbol_packer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .char_in(char_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .packed_code(packed_code),
    .is_line_end(is_line_end),
    .line_error(line_error),
    .line_count(line_count),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("kmer_symbol_packer: mismatch");
    $finish;
  end

  function automatic logic [8:0] lookup_symbol(input logic [7:0] c, input logic [1:0] mode);
    logic [7:0] s;
    logic       ok;
    ok = 1'b1;
    s = 8'd0;
    case (mode)
      MODE_PROTEIN: begin
        if (c < CH_LO_A || c > CH_LO_Y || c == CH_LO_B || c == CH_LO_J ||
            c == CH_LO_O || c == CH_LO_U)
          ok = 1'b0;
        else
          s = c - CH_LO_A - 8'(c > CH_LO_B) - 8'(c > CH_LO_J) - 8'(c > CH_LO_O)
              - 8'(c > CH_LO_U);
      end
      MODE_ALNUM: begin
        if (c >= CH_LO_A && c <= CH_LO_Z)
          s = c - CH_LO_A;
        else if (c >= CH_0 && c <= CH_9)
          s = 8'(DIGIT_BASE) + (c - CH_0);
        else
          ok = 1'b0;
      end
      MODE_DIE: begin
        if (c >= CH_1 && c <= CH_6)
          s = c - CH_1;
        else
          ok = 1'b0;
      end
      default: begin
        case (c)
          CH_UP_A: s = 8'd0;
          CH_UP_C: s = 8'd1;
          CH_UP_G: s = 8'd2;
          CH_UP_T: s = 8'd3;
          CH_UP_N: s = 8'd4;
          CH_LO_N: s = 8'd5;
          default: ok = 1'b0;
        endcase
      end
    endcase
    return {ok, s};
  endfunction

  task automatic pack_char(input logic [7:0] c);
    int          bps;
    int          ord;
    int          total;
    logic [8:0]  hit;
    logic [7:0]  sym;
    logic [63:0] w;
    logic        fire;
    out_beat_t   b;
    if (c == CH_NL) begin
      b.code = 16'd0;
      b.line_end = 1'b1;
      b.err = err_m;
      b.count = emit_m;
      beats_due.push_back(b);
      win_m = 16'd0;
      pos_m = 16'd0;
      emit_m = 16'd0;
      err_m = 1'b0;
      return;
    end
    bps = int'(shadow.bits_per_symbol);
    if (bps < 1) bps = 1;
    if (bps > 8) bps = 8;
    ord = int'(shadow.window_order);
    if (ord < 1) ord = 1;
    if (ord > 16) ord = 16;
    hit = lookup_symbol(c, shadow.alphabet_mode);
    sym = hit[7:0];
    if (!hit[8] || sym >= shadow.symbol_limit) begin
      err_m = 1'b1;
      sym = 8'd0;
    end
    sym = sym & 8'((1 << bps) - 1);
    total = bps * ord;
    w = ({48'd0, win_m} << bps) | {56'd0, sym};
    if (total < 64)
      w = w & ((64'd1 << total) - 64'd1);
    win_m = w[15:0];
    fire = (pos_m >= shadow.start_skip) &&
           (shadow.max_width == 16'd0 || emit_m < shadow.max_width);
    if (pos_m != 16'hFFFF) pos_m = pos_m + 16'd1;
    if (fire) begin
      if (emit_m != 16'hFFFF) emit_m = emit_m + 16'd1;
      b.code = win_m;
      b.line_end = 1'b0;
      b.err = 1'b0;
      b.count = 16'd0;
      beats_due.push_back(b);
    end
  endtask

  function automatic logic [7:0] pick_char(input logic [1:0] mode);
    logic [7:0] c;
    logic [7:0] dna_set [6] = '{CH_UP_A, CH_UP_C, CH_UP_G, CH_UP_T, CH_UP_N, CH_LO_N};
    if ($urandom_range(99) < 20)
      return 8'($urandom_range(255));
    case (mode)
      MODE_PROTEIN: begin
        c = CH_LO_B;
        while (c == CH_LO_B || c == CH_LO_J || c == CH_LO_O || c == CH_LO_U)
          c = CH_LO_A + 8'($urandom_range(24));
      end
      MODE_ALNUM: begin
        if ($urandom_range(1) == 0)
          c = CH_LO_A + 8'($urandom_range(25));
        else
          c = CH_0 + 8'($urandom_range(9));
      end
      MODE_DIE: c = CH_1 + 8'($urandom_range(5));
      default: c = dna_set[$urandom_range(5)];
    endcase
    return c;
  endfunction

  function automatic void log_fault(input string msg);
    bad_beats++;
    if (bad_beats <= SHOW_LIMIT)
      $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    out_beat_t got;
    out_beat_t want;
    out_ready <= gaps_on ? ($urandom_range(99) >= GAP_PCT) : 1'b1;
    if (!rst && out_valid && out_ready) begin
      got.code = packed_code;
      got.line_end = is_line_end;
      got.err = line_error;
      got.count = line_count;
      if (beats_due.size() == 0) begin
        log_fault($sformatf("unexpected beat: code %h end %b err %b count %0d",
                            got.code, got.line_end, got.err, got.count));
      end else begin
        want = beats_due.pop_front();
        if (got !== want)
          log_fault($sformatf({"beat differs: want code %h end %b err %b count %0d,",
                               " got code %h end %b err %b count %0d"},
            want.code, want.line_end, want.err, want.count,
            got.code, got.line_end, got.err, got.count));
      end
    end
  end

  task automatic send_char(input logic [7:0] c);
    if (gaps_on)
      while ($urandom_range(99) < GAP_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid <= 1'b1;
    char_in <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pack_char(c);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i]);
  endtask

  task automatic drain_out(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (beats_due.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_ALPHABET:  shadow.alphabet_mode = value[1:0];
      REG_SYM_LIMIT: shadow.symbol_limit = value[7:0];
      REG_BPS:       shadow.bits_per_symbol = value[3:0];
      REG_ORDER:     shadow.window_order = value[4:0];
      REG_SKIP:      shadow.start_skip = value;
      REG_MAX_WIDTH: shadow.max_width = value;
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [1:0] mode, input logic [7:0] limit,
                             input logic [3:0] bps, input logic [4:0] ord,
                             input logic [15:0] skip, input logic [15:0] width);
    logic [15:0] noise;
    noise = 16'($urandom);
    write_reg(REG_SPARE, noise);
    write_reg(REG_ALPHABET, {noise[15:2], mode});
    write_reg(REG_SYM_LIMIT, {noise[7:0], limit});
    write_reg(REG_BPS, {noise[11:0], bps});
    write_reg(REG_ORDER, {noise[10:0], ord});
    write_reg(REG_SKIP, skip);
    write_reg(REG_MAX_WIDTH, width);
    cfg_we <= 1'b0;
  endtask

  task automatic test_dna_defaults();
    send_str("ACGTNn");
    send_char(8'h00);
    send_char(8'hFF);
    send_str("\n\n");
    drain_out(SETTLE_CYCLES);
  endtask

  task automatic test_register_clamps();
    load_config(MODE_ALNUM, 8'd255, 4'd0, 5'd0, 16'd0, 16'd0);
    send_str("az09\n");
    drain_out(SETTLE_CYCLES);
    load_config(MODE_ALNUM, 8'd255, 4'd15, 5'd31, 16'd0, 16'd0);
    send_str("z9a\n");
    drain_out(SETTLE_CYCLES);
  endtask

  task automatic test_protein_and_die();
    load_config(MODE_PROTEIN, 8'd21, 4'd8, 5'd16, 16'd1, 16'hFFFF);
    send_str("abyj\n");
    drain_out(SETTLE_CYCLES);
    load_config(MODE_DIE, 8'd1, 4'd3, 5'd4, 16'd0, 16'd1);
    send_str("1627\n");
    drain_out(SETTLE_CYCLES);
  endtask

  task automatic test_random_lines();
    int          sent;
    int          len;
    logic [1:0]  mode;
    logic [7:0]  limit;
    logic [3:0]  bps;
    logic [4:0]  ord;
    logic [15:0] skip;
    logic [15:0] width;
    for (int phase = 0; phase < 8; phase++) begin
      mode = 2'($urandom_range(3));
      case ($urandom_range(9))
        0: limit = 8'd0;
        1: limit = 8'd1;
        2: limit = 8'd255;
        default: limit = 8'($urandom_range(40, 1));
      endcase
      case ($urandom_range(9))
        0: bps = 4'd0;
        1: bps = 4'd8;
        2: bps = 4'd15;
        default: bps = 4'($urandom_range(8, 1));
      endcase
      case ($urandom_range(9))
        0: ord = 5'd0;
        1: ord = 5'd16;
        2: ord = 5'd31;
        default: ord = 5'($urandom_range(16, 1));
      endcase
      case ($urandom_range(9))
        0: skip = 16'hFFFF;
        1: skip = 16'($urandom_range(65535));
        default: skip = 16'($urandom_range(4));
      endcase
      case ($urandom_range(9))
        0: width = 16'hFFFF;
        1: width = 16'($urandom_range(65535));
        default: width = 16'($urandom_range(6));
      endcase
      gaps_on = (phase != 2);
      load_config(mode, limit, bps, ord, skip, width);
      sent = 0;
      while (sent < 50) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10);
        repeat (len) begin
          send_char(pick_char(mode));
          sent++;
          if ($urandom_range(39) == 0)
            drain_out(0);
        end
        send_char(CH_NL);
        sent++;
      end
      drain_out(SETTLE_CYCLES);
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    char_in = 8'd0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_ALPHABET;
    cfg_data = '0;
    gaps_on = 1'b1;
    bad_beats = 0;
    shadow.alphabet_mode = MODE_DNA;
    shadow.symbol_limit = 8'd4;
    shadow.bits_per_symbol = 4'd2;
    shadow.window_order = 5'd1;
    shadow.start_skip = 16'd0;
    shadow.max_width = 16'd0;
    win_m = 16'd0;
    pos_m = 16'd0;
    emit_m = 16'd0;
    err_m = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_dna_defaults();
    test_register_clamps();
    test_protein_and_die();
    test_random_lines();
    drain_out(8);
    if (bad_beats == 0 && beats_due.size() == 0)
      $display("kmer_symbol_packer: match");
    else
      $display("kmer_symbol_packer: mismatch");
    $finish;
  end

endmodule

[kmer_symbol_packer.f]
src/kmer_pkg.sv
src/kmer_cfg_regs.sv
src/kmer_sym_map.sv
src/kmer_symbol_packer.sv
bench/tb_top.sv
